[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while the synchronous reset is active.
`define HM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define HM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/hmtp_pkg.sv]
// ----------------------------------------------------------------------------
// hmtp_pkg
// Types, constants and helper functions of the height map token parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hmtp_pkg;

    localparam int unsigned MAX_COLUMNS_DEF = 4096;
    localparam int unsigned MAX_ROWS_DEF    = 4096;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned COL_W    = 12;
    localparam int unsigned HEIGHT_W = 32;
    localparam int unsigned COLOUR_W = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [COLOUR_W-1:0] DEFAULT_COLOUR_RST = 32'h00FF_FFFF;
    localparam logic [HEIGHT_W:0]   MAG_CAP            = 33'h0_8000_0000;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX         = 32'h7FFF_FFFF;
    localparam logic [3:0]          HEX_MAX_DIGITS     = 4'd8;

    localparam logic [CH_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CHR_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CHR_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CHR_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CHR_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHR_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CHR_UPX   = 8'h58;
    localparam logic [CH_W-1:0] CHR_LOWX  = 8'h78;
    localparam logic [CH_W-1:0] CHR_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CHR_CR    = 8'h0D;

    // Register map, index = byte address / 4
    localparam logic [0:0] REG_DEFAULT_COLOUR = 1'b0;

    typedef enum logic [2:0] {
        PH_BETWEEN,
        PH_DIGITS,
        PH_JUNK,
        PH_PFX0,
        PH_PFXX,
        PH_HEX,
        PH_REST
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_PREFIX,
        ST_BAD_HEX,
        ST_TOO_LONG
    } t_status;

    typedef struct packed {
        t_phase                phase;
        logic [HEIGHT_W-1:0]   height_acc;
        logic                  negative;
        logic [COLOUR_W-1:0]   colour_acc;
        logic                  colour_given;
        logic [3:0]            hex_count;
        t_status               err;
    } t_tok_state;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex_digit;

    function automatic t_hex_digit hex_digit(input logic [CH_W-1:0] c);
        t_hex_digit d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.ok    = 1'b1;
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.ok    = 1'b1;
            d.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.ok    = 1'b1;
            d.value = 4'(c - 8'h57);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hmtp_if.sv]
// ----------------------------------------------------------------------------
// hmtp_if
// Valid/ready channels of the height map token parser: character in, point out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hmtp_tok_if;
    logic                           valid;
    logic                           ready;
    logic [hmtp_pkg::CH_W-1:0]      ch;
    logic                           line_end;
    logic [hmtp_pkg::ROW_W-1:0]     row;

    modport source (output valid, output ch, output line_end, output row, input ready);
    modport sink   (input valid, input ch, input line_end, input row, output ready);
endinterface

interface hmtp_pt_if;
    logic                                  valid;
    logic                                  ready;
    logic        [hmtp_pkg::COL_W-1:0]     column;
    logic        [hmtp_pkg::ROW_W-1:0]     row_out;
    logic signed [hmtp_pkg::HEIGHT_W-1:0]  height;
    logic        [hmtp_pkg::COLOUR_W-1:0]  colour;
    logic        [hmtp_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output column, output row_out, output height,
                    output colour, output status, input ready);
    modport sink   (input valid, input column, input row_out, input height,
                    input colour, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/height_map_token_parser_core.sv]
// ----------------------------------------------------------------------------
// height_map_token_parser_core
// Splits map text into height/colour points, one character per transaction.
// ----------------------------------------------------------------------------
// Takes one character per clock and returns one point per token in the cycle
// after the transaction that ends the token (a space, a NUL, or the character
// flagged as the line's last). The parser state loop is combinational
// (phase update, multiply-by-ten add, hex shift), so a character can follow
// every cycle; the output register lets a new character in while a point
// still waits, and i_tok.ready drops only when that point is stalled.
// default_colour sits at byte address 0 and should be written while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module height_map_token_parser_core #(
    parameter int unsigned MAX_COLUMNS = hmtp_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = hmtp_pkg::MAX_ROWS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    hmtp_tok_if.sink                            i_tok,
    hmtp_pt_if.source                           o_pt,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hmtp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [hmtp_pkg::PDATA_W-1:0]   pwdata,
    output      logic [hmtp_pkg::PDATA_W-1:0]   prdata,
    output      logic                           pready
);

    localparam int unsigned CNT_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [CNT_W-1:0] COL_LAST = CNT_W'(MAX_COLUMNS - 1);
    localparam logic [31:0]      ROW_LAST = 32'(MAX_ROWS - 1);

    // ---------------- configuration ----------------
    logic [hmtp_pkg::COLOUR_W-1:0] r_default_colour;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_colour <= hmtp_pkg::DEFAULT_COLOUR_RST;
        end else if (cfg_wr && paddr[2] == hmtp_pkg::REG_DEFAULT_COLOUR) begin
            r_default_colour <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == hmtp_pkg::REG_DEFAULT_COLOUR) begin
            prdata = r_default_colour;
        end
    end

    // ---------------- parser state ----------------
    hmtp_pkg::t_tok_state r_st, n_st, w_st;
    logic [CNT_W-1:0]     r_col, n_col;
    logic                 r_out_valid, n_out_valid;

    logic                 accept;
    logic                 term;
    logic                 ws;
    logic                 do_take;
    logic                 emit;
    logic [hmtp_pkg::CH_W-1:0] c;
    hmtp_pkg::t_hex_digit hd;
    logic [hmtp_pkg::HEIGHT_W+3:0] mul10;

    assign c      = i_tok.ch;
    assign accept = i_tok.valid && i_tok.ready;
    assign i_tok.ready = !r_out_valid || o_pt.ready;

    assign term = (c == hmtp_pkg::CHR_SPACE) || (c == hmtp_pkg::CHR_NUL);
    assign ws   = (c == hmtp_pkg::CHR_SPACE) ||
                  (c >= hmtp_pkg::CHR_TAB && c <= hmtp_pkg::CHR_CR);
    assign hd   = hmtp_pkg::hex_digit(c);

    // Next state: open token, take the character, close token.
    always_comb begin
        w_st    = r_st;
        do_take = 1'b0;
        mul10   = '0;

        if (r_st.phase == hmtp_pkg::PH_BETWEEN) begin
            if (!term && !ws) begin
                w_st       = '0;
                w_st.phase = hmtp_pkg::PH_DIGITS;
                if (c == hmtp_pkg::CHR_MINUS) begin
                    w_st.negative = 1'b1;
                end else if (c != hmtp_pkg::CHR_PLUS) begin
                    do_take = 1'b1;
                end
            end
        end else if (!term) begin
            do_take = 1'b1;
        end

        if (do_take) begin
            case (w_st.phase)
                hmtp_pkg::PH_DIGITS: begin
                    if (c >= hmtp_pkg::CHR_ZERO && c <= hmtp_pkg::CHR_NINE) begin
                        mul10 = ({4'b0, w_st.height_acc} << 3) +
                                ({4'b0, w_st.height_acc} << 1) +
                                36'(c - hmtp_pkg::CHR_ZERO);
                        if (mul10 > 36'(hmtp_pkg::MAG_CAP)) begin
                            w_st.height_acc = hmtp_pkg::MAG_CAP[hmtp_pkg::HEIGHT_W-1:0];
                        end else begin
                            w_st.height_acc = mul10[hmtp_pkg::HEIGHT_W-1:0];
                        end
                    end else if (c == hmtp_pkg::CHR_COMMA) begin
                        w_st.colour_given = 1'b1;
                        w_st.phase        = hmtp_pkg::PH_PFX0;
                    end else begin
                        w_st.phase = hmtp_pkg::PH_JUNK;
                    end
                end
                hmtp_pkg::PH_JUNK: begin
                    if (c == hmtp_pkg::CHR_COMMA) begin
                        w_st.colour_given = 1'b1;
                        w_st.phase        = hmtp_pkg::PH_PFX0;
                    end
                end
                hmtp_pkg::PH_PFX0: begin
                    if (c == hmtp_pkg::CHR_ZERO) begin
                        w_st.phase = hmtp_pkg::PH_PFXX;
                    end else begin
                        w_st.err   = hmtp_pkg::ST_NO_PREFIX;
                        w_st.phase = hmtp_pkg::PH_REST;
                    end
                end
                hmtp_pkg::PH_PFXX: begin
                    if (c == hmtp_pkg::CHR_UPX || c == hmtp_pkg::CHR_LOWX) begin
                        w_st.phase = hmtp_pkg::PH_HEX;
                    end else begin
                        w_st.err   = hmtp_pkg::ST_NO_PREFIX;
                        w_st.phase = hmtp_pkg::PH_REST;
                    end
                end
                hmtp_pkg::PH_HEX: begin
                    if (!hd.ok) begin
                        w_st.err   = hmtp_pkg::ST_BAD_HEX;
                        w_st.phase = hmtp_pkg::PH_REST;
                    end else if (w_st.hex_count >= hmtp_pkg::HEX_MAX_DIGITS) begin
                        w_st.err   = hmtp_pkg::ST_TOO_LONG;
                        w_st.phase = hmtp_pkg::PH_REST;
                    end else begin
                        w_st.colour_acc = {w_st.colour_acc[hmtp_pkg::COLOUR_W-5:0], hd.value};
                        w_st.hex_count  = w_st.hex_count + 4'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        emit = (w_st.phase != hmtp_pkg::PH_BETWEEN) && (term || i_tok.line_end);

        n_st  = r_st;
        n_col = r_col;
        if (accept) begin
            n_st = w_st;
            if (emit) begin
                n_st.phase = hmtp_pkg::PH_BETWEEN;
                if (r_col < COL_LAST) begin
                    n_col = r_col + 1'b1;
                end
            end
            if (i_tok.line_end) begin
                n_col = '0;
            end
        end
    end

    // Result fields of the token closed by this character.
    hmtp_pkg::t_status             res_status;
    logic [hmtp_pkg::HEIGHT_W-1:0] res_height;
    logic [hmtp_pkg::COLOUR_W-1:0] res_colour;
    logic [hmtp_pkg::ROW_W-1:0]    res_row;
    logic [31:0]                   col_ext;

    always_comb begin
        res_status = w_st.err;
        if ((w_st.phase == hmtp_pkg::PH_PFX0 || w_st.phase == hmtp_pkg::PH_PFXX) &&
            w_st.err == hmtp_pkg::ST_OK) begin
            res_status = hmtp_pkg::ST_NO_PREFIX;
        end

        if (w_st.negative) begin
            res_height = '0 - w_st.height_acc;
        end else if (w_st.height_acc > hmtp_pkg::HEIGHT_MAX) begin
            res_height = hmtp_pkg::HEIGHT_MAX;
        end else begin
            res_height = w_st.height_acc;
        end

        if (res_status != hmtp_pkg::ST_OK) begin
            res_colour = '0;
        end else if (w_st.colour_given) begin
            res_colour = w_st.colour_acc;
        end else begin
            res_colour = r_default_colour;
        end

        if (32'(i_tok.row) > ROW_LAST) begin
            res_row = ROW_LAST[hmtp_pkg::ROW_W-1:0];
        end else begin
            res_row = i_tok.row;
        end

        col_ext = 32'(r_col);
    end

    // ---------------- registers ----------------
    always_comb begin
        if (accept) begin
            n_out_valid = emit;
        end else begin
            n_out_valid = r_out_valid && !o_pt.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    // Load the point only when a token closes; hold it otherwise.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            o_pt.column  <= col_ext[hmtp_pkg::COL_W-1:0];
            o_pt.row_out <= res_row;
            o_pt.height  <= res_height;
            o_pt.colour  <= res_colour;
            o_pt.status  <= res_status;
        end
    end

    assign o_pt.valid = r_out_valid;

    // ---------------- assertions ----------------
    `HM_ASSERT(a_col_clear, i_clk, i_rst_n, accept && i_tok.line_end |=> r_col == '0, "column not cleared after line end")
    `HM_ASSERT(a_space_emits, i_clk, i_rst_n, accept && r_st.phase != hmtp_pkg::PH_BETWEEN && term |=> o_pt.valid, "open token not closed by separator")
    `HM_ASSERT(a_hex_has_comma, i_clk, i_rst_n, r_st.phase == hmtp_pkg::PH_HEX |-> r_st.colour_given && r_st.hex_count <= hmtp_pkg::HEX_MAX_DIGITS, "hex phase without colour part")
    `HM_ASSERT_ALWAYS(a_ready_when_empty, i_clk, !r_out_valid |-> i_tok.ready, "input stalled with empty output register")

endmodule

`default_nettype wire

[tb/hmtp_point_sb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmtp_point_sb_pkg
// Point predictor and scoreboard for the height map token parser bench.
// ----------------------------------------------------------------------------
// Mirrors the token parser state for every accepted character, queues the
// point each finished token must produce and compares delivered points with
// the oldest queued one.
// ----------------------------------------------------------------------------

package hmtp_point_sb_pkg;
    import hmtp_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row_out;
        logic [HEIGHT_W-1:0] height;
        logic [COLOUR_W-1:0] colour;
        logic [STATUS_W-1:0] status;
    } t_map_point;

    class map_point_scoreboard;
        int unsigned         max_rows;
        int unsigned         max_cols;
        logic [COLOUR_W-1:0] default_colour;
        t_phase              phase;
        logic [HEIGHT_W-1:0] magnitude;
        logic                negative;
        logic [COLOUR_W-1:0] colour_acc;
        logic                colour_given;
        logic [3:0]          hex_digits;
        int unsigned         column_count;
        t_status             status;
        t_map_point          expected_points[$];
        int unsigned         mismatches;

        function new(int unsigned rows, int unsigned cols);
            max_rows       = rows;
            max_cols       = cols;
            default_colour = DEFAULT_COLOUR_RST;
            phase          = PH_BETWEEN;
            magnitude      = '0;
            negative       = 1'b0;
            colour_acc     = '0;
            colour_given   = 1'b0;
            hex_digits     = '0;
            column_count   = 0;
            status         = ST_OK;
            mismatches     = 0;
        endfunction

        function void set_default_colour(logic [COLOUR_W-1:0] value);
            default_colour = value;
        endfunction

        function int unsigned pending();
            return expected_points.size();
        endfunction

        // Keep only the first colour error, skip the rest of the token.
        function void mark_error(t_status code);
            if (status == ST_OK) begin
                status = code;
            end
            phase = PH_REST;
        endfunction

        function void take_char(logic [CH_W-1:0] c);
            logic [35:0] scaled;
            logic        digit_ok;
            logic [3:0]  digit_val;
            digit_ok = 1'b1;
            if (c >= CHR_ZERO && c <= CHR_NINE) begin
                digit_val = c[3:0];
            end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
                digit_val = c[3:0] + 4'd9;
            end else begin
                digit_ok  = 1'b0;
                digit_val = '0;
            end
            case (phase)
                PH_DIGITS: begin
                    if (c >= CHR_ZERO && c <= CHR_NINE) begin
                        scaled    = {4'b0, magnitude} * 36'd10 + 36'(c - CHR_ZERO);
                        magnitude = (scaled > 36'h0_8000_0000) ? 32'h8000_0000 : scaled[31:0];
                    end else if (c == CHR_COMMA) begin
                        colour_given = 1'b1;
                        phase        = PH_PFX0;
                    end else begin
                        phase = PH_JUNK;
                    end
                end
                PH_JUNK: begin
                    if (c == CHR_COMMA) begin
                        colour_given = 1'b1;
                        phase        = PH_PFX0;
                    end
                end
                PH_PFX0: begin
                    if (c == CHR_ZERO) phase = PH_PFXX;
                    else mark_error(ST_NO_PREFIX);
                end
                PH_PFXX: begin
                    if (c == CHR_UPX || c == CHR_LOWX) phase = PH_HEX;
                    else mark_error(ST_NO_PREFIX);
                end
                PH_HEX: begin
                    if (!digit_ok) begin
                        mark_error(ST_BAD_HEX);
                    end else if (hex_digits >= HEX_MAX_DIGITS) begin
                        mark_error(ST_TOO_LONG);
                    end else begin
                        colour_acc = {colour_acc[COLOUR_W-5:0], digit_val};
                        hex_digits = hex_digits + 4'd1;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Advance the parser by one accepted character transaction.
        function void note_char(logic [CH_W-1:0] c, logic last, logic [ROW_W-1:0] row);
            logic                term;
            logic [HEIGHT_W-1:0] h;
            int unsigned         r;
            t_map_point          point;
            term = (c == CHR_SPACE) || (c == CHR_NUL);
            if (phase == PH_BETWEEN) begin
                if (!term && !(c >= CHR_TAB && c <= CHR_CR)) begin
                    magnitude    = '0;
                    negative     = 1'b0;
                    colour_acc   = '0;
                    colour_given = 1'b0;
                    hex_digits   = '0;
                    status       = ST_OK;
                    phase        = PH_DIGITS;
                    if (c == CHR_MINUS) negative = 1'b1;
                    else if (c != CHR_PLUS) take_char(c);
                end
            end else if (!term) begin
                take_char(c);
            end
            if (phase != PH_BETWEEN && (term || last)) begin
                if (phase == PH_PFX0 || phase == PH_PFXX) begin
                    mark_error(ST_NO_PREFIX);
                end
                if (negative) h = -magnitude;
                else h = (magnitude > HEIGHT_MAX) ? HEIGHT_MAX : magnitude;
                r = row;
                if (r > max_rows - 1) r = max_rows - 1;
                point.column  = COL_W'(column_count);
                point.row_out = ROW_W'(r);
                point.height  = h;
                point.colour  = (status != ST_OK) ? '0 :
                                (colour_given ? colour_acc : default_colour);
                point.status  = status;
                expected_points.push_back(point);
                if (column_count < max_cols - 1) column_count++;
                phase = PH_BETWEEN;
            end
            if (last) begin
                column_count = 0;
            end
        endfunction

        function void check_point(t_map_point got);
            t_map_point want;
            if (expected_points.size() == 0) begin
                $error("point with no expectation: column %0d row %0d height %0d",
                       got.column, got.row_out, $signed(got.height));
                mismatches++;
                return;
            end
            want = expected_points.pop_front();
            if (got.column !== want.column) begin
                $error("column: expected %0d, actual %0d", want.column, got.column);
                mismatches++;
            end
            if (got.row_out !== want.row_out) begin
                $error("row_out: expected %0d, actual %0d", want.row_out, got.row_out);
                mismatches++;
            end
            if (got.height !== want.height) begin
                $error("height: expected %0d, actual %0d",
                       $signed(want.height), $signed(got.height));
                mismatches++;
            end
            if (got.colour !== want.colour) begin
                $error("colour: expected %08h, actual %08h", want.colour, got.colour);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[tb/height_map_token_parser_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_map_token_parser_core_tb
// Self-checking bench of the height map token parser core.
// ----------------------------------------------------------------------------
// Streams map text lines into the parser: a short directed line with the
// corner cases, random lines built mostly from well-formed height/colour
// tokens plus noise, and one long line of short tokens sent back to back.
// The default colour is rewritten between phases. Sender bursts and gaps and
// receiver stalls are random; points are checked by the scoreboard class.
// ----------------------------------------------------------------------------

module height_map_token_parser_core_tb;
    import hmtp_pkg::*;
    import hmtp_point_sb_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned HOLD_CYCLES      = 400;
    localparam int unsigned LONG_LINE_TOKENS = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    hmtp_tok_if tok_ch ();
    hmtp_pt_if  pt_ch ();

    height_map_token_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_ch),
        .o_pt    (pt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    map_point_scoreboard points;
    logic [CH_W-1:0]     line_chars[$];
    logic [ROW_W-1:0]    row_now;
    int unsigned         burst_left;
    int unsigned         gap_limit;
    int unsigned         chars_sent;
    int unsigned         hold_request;
    int unsigned         cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic write_default_colour(input logic [COLOUR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_DEFAULT_COLOUR, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        points.set_default_colour(value);
    endtask

    // Offer one character, idling between bursts.
    task automatic send_char(input logic [CH_W-1:0] c, input logic last,
                             input logic [ROW_W-1:0] r);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = $urandom_range(0, gap_limit);
            if (gap > 0) begin
                tok_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        tok_ch.valid    <= 1'b1;
        tok_ch.ch       <= c;
        tok_ch.line_end <= last;
        tok_ch.row      <= r;
        do @(posedge i_clk); while (!tok_ch.ready);
        points.note_char(c, last, r);
        chars_sent++;
    endtask

    task automatic send_line(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] char_row;
        for (int i = 0; i < line_chars.size(); i++) begin
            // Now and then change row inside a line.
            char_row = ($urandom_range(0, 49) == 0) ? ROW_W'($urandom) : r;
            send_char(line_chars[i], i == line_chars.size() - 1, char_row);
        end
        line_chars.delete();
    endtask

    // Hold the sender until every point has come out, then let the core settle.
    task automatic wait_drained();
        tok_ch.valid <= 1'b0;
        while (points.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
    endfunction

    function automatic void add_digits(input int unsigned n);
        repeat (n) line_chars.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void add_hex(input int unsigned n);
        int unsigned v;
        repeat (n) begin
            v = $urandom_range(0, 15);
            if (v < 10) line_chars.push_back(CHR_ZERO + 8'(v));
            else line_chars.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 10));
        end
    endfunction

    function automatic void add_noise();
        repeat ($urandom_range(1, 6)) line_chars.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_token();
        int unsigned pick;
        logic [CH_W-1:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 20) line_chars.push_back(CHR_MINUS);
        else if (pick < 30) line_chars.push_back(CHR_PLUS);
        pick = $urandom_range(0, 99);
        if (pick < 8) add_digits($urandom_range(10, 12));
        else if (pick >= 12) add_digits($urandom_range(1, 5));
        if ($urandom_range(0, 9) == 0) begin
            do c = 8'($urandom_range(1, 255)); while (c == CHR_SPACE);
            line_chars.push_back(c);
        end
        if ($urandom_range(0, 1) == 1) begin
            line_chars.push_back(CHR_COMMA);
            pick = $urandom_range(0, 99);
            if (pick < 92) begin
                line_chars.push_back(CHR_ZERO);
                if (pick < 88) begin
                    line_chars.push_back($urandom_range(0, 1) ? CHR_UPX : CHR_LOWX);
                    if (pick < 70) begin
                        add_hex($urandom_range(0, 8));
                    end else if (pick < 78) begin
                        add_hex($urandom_range(9, 11));
                    end else begin
                        add_hex($urandom_range(0, 7));
                        line_chars.push_back($urandom_range(0, 1) ? CHR_COMMA :
                                             8'($urandom_range(8'h67, 8'h7A)));
                        if ($urandom_range(0, 1) == 1) add_hex($urandom_range(1, 3));
                    end
                end
            end
        end
    endfunction

    function automatic void build_random_line();
        int unsigned count;
        count = $urandom_range(1, 6);
        if ($urandom_range(0, 4) == 0) line_chars.push_back(8'($urandom_range(9, 13)));
        for (int t = 0; t < count; t++) begin
            if ($urandom_range(0, 9) == 0) add_noise();
            else add_token();
            if (t < count - 1 || $urandom_range(0, 1) == 1) begin
                line_chars.push_back(($urandom_range(0, 7) == 0) ? CHR_NUL : CHR_SPACE);
                if ($urandom_range(0, 3) == 0) begin
                    line_chars.push_back(8'($urandom_range(9, 13)));
                end
            end
        end
        if (line_chars.size() == 0) line_chars.push_back(CHR_SPACE);
    endfunction

    task automatic run_random_lines(input int unsigned n);
        int unsigned goal;
        goal = chars_sent + n;
        while (chars_sent < goal) begin
            case ($urandom_range(0, 9))
                0: row_now = '0;
                1: row_now = '1;
                2: row_now = ROW_W'($urandom);
                default: row_now = row_now + 1'b1;
            endcase
            case ($urandom_range(0, 3))
                0: gap_limit = 0;
                1: gap_limit = 2;
                2: gap_limit = 6;
                default: gap_limit = 16;
            endcase
            build_random_line();
            send_line(row_now);
        end
    endtask

    // Point receiver: random stall pattern plus an occasional long hold-off.
    initial begin : point_sink
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned ready_pct;
        t_map_point  got;
        pt_ch.ready <= 1'b0;
        hold_left = 0;
        mode_left = 0;
        ready_pct = 100;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pt_ch.valid && pt_ch.ready) begin
                got.column  = pt_ch.column;
                got.row_out = pt_ch.row_out;
                got.height  = pt_ch.height;
                got.colour  = pt_ch.colour;
                got.status  = pt_ch.status;
                points.check_point(got);
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                pt_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 70;
                        2: ready_pct = 40;
                        default: ready_pct = 10;
                    endcase
                end
                mode_left--;
                pt_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    initial begin : stimulus
        points = new(MAX_ROWS_DEF, MAX_COLUMNS_DEF);
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        tok_ch.valid    <= 1'b0;
        tok_ch.ch       <= '0;
        tok_ch.line_end <= 1'b0;
        tok_ch.row      <= '0;
        row_now      = '0;
        burst_left   = 0;
        gap_limit    = 4;
        chars_sent   = 0;
        hold_request = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner cases under the reset default colour: leading tab, signs, junk
        // before the comma, mixed-case hex, empty hex part, comma or lone zero
        // at token end, NUL as separator, too many hex digits, line end inside
        // a token.
        add_text("\t+9x,0XaF -,0x 5,");
        line_chars.push_back(CHR_NUL);
        add_text("1,0 3,0x123456789g");
        send_line('1);
        wait_drained();

        write_default_colour('0);
        run_random_lines(210);
        // Stall the receiver while characters keep coming.
        hold_request = HOLD_CYCLES;
        run_random_lines(210);
        wait_drained();

        write_default_colour('1);
        run_random_lines(430);
        wait_drained();

        write_default_colour($urandom);
        run_random_lines(390);
        wait_drained();

        // One long line of short tokens, sent without gaps.
        write_default_colour(DEFAULT_COLOUR_RST);
        gap_limit = 0;
        for (int t = 0; t < LONG_LINE_TOKENS; t++) begin
            if ($urandom_range(0, 19) == 0) add_token();
            else line_chars.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
            line_chars.push_back(CHR_SPACE);
        end
        send_line(row_now);
        wait_drained();

        if (points.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
